>>> rtl/lph_pkg.sv
// Package: shared types and constants for the linear probe hash table.
`timescale 1ns / 1ps
package lph_pkg;
	localparam int TableSize = 256;
	localparam int IdxW = $clog2(TableSize);
	localparam int KeyW = 64;
	localparam int ValW = 32;
	localparam int CntW = 9;
	localparam logic [31:0] FnvBasis = 32'd2166136261;
	localparam logic [31:0] FnvPrime = 32'd16777619;
	localparam logic [1:0] FUNC_GET = 2'd0;
	localparam logic [1:0] FUNC_PUT = 2'd1;
	localparam logic [1:0] FUNC_REM = 2'd2;
	localparam logic [1:0] FUNC_NOP = 2'd3;
	localparam logic [1:0] MARK_EMPTY = 2'd0;
	localparam logic [1:0] MARK_LIVE = 2'd1;
	localparam logic [1:0] MARK_TOMB = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE, ST_HASH, ST_READ, ST_CHECK, ST_DONE
	} lph_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // capture request
		logic hash_step; // one FNV byte
		logic set_home;  // slot index from hash
		logic rd;        // issue slot read
		logic advance;   // next slot
		logic commit;    // apply decision, write result
	} lph_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic hash_done;
		logic stop;      // probe terminates at this slot
		logic last;      // probe budget exhausted
	} lph_sts_t;
endpackage

>>> rtl/lph_datapath.sv
// Datapath: hashing, slot memories, probe compare and result registers.
`timescale 1ns / 1ps
module lph_datapath import lph_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  lph_cmd_t        cmd,
	output lph_sts_t        sts,
	input  logic [1:0]      func,
	input  logic [KeyW-1:0] key_bytes,
	input  logic [3:0]      key_len,
	input  logic [ValW-1:0] put_value,
	output logic            found,
	output logic [ValW-1:0] get_value,
	output logic            status,
	output logic [CntW-1:0] live_entries
);
	logic [1:0]      func_q;
	logic [KeyW-1:0] key_q;
	logic [3:0]      len_q, byte_q;
	logic [ValW-1:0] val_q;
	logic [31:0]     hash_q;
	logic [IdxW-1:0] slot_q;
	logic [IdxW:0]   nprobe_q;
	logic [CntW-1:0] live_q;
	logic [TableSize-1:0] valid_q;
	logic [1:0]      mark_mem [TableSize];
	logic [KeyW-1:0] key_mem  [TableSize];
	logic [3:0]      len_mem  [TableSize];
	logic [ValW-1:0] val_mem  [TableSize];
	logic [1:0]      rmark_q;
	logic [KeyW-1:0] rkey_q;
	logic [3:0]      rlen_q;
	logic [ValW-1:0] rval_q;
	logic [1:0]      mark;
	logic            match;
	logic [3:0]      len_sat;
	logic [KeyW-1:0] kmask;
	logic [7:0]      kbyte;
	logic [31:0]     hx;

	assign len_sat = (key_len > 4'd8) ? 4'd8 : key_len;
	always_comb begin
		kmask = '0;
		for (int i = 0; i < 8; i++)
			if (4'(i) < len_sat) kmask[i*8 +: 8] = 8'hFF;
	end

	// byte-serial FNV-1a with sign-extended bytes
	assign kbyte = key_q[byte_q[2:0]*8 +: 8];
	assign hx = hash_q ^ {{24{kbyte[7]}}, kbyte};

	// slot status, unwritten marks read empty
	assign mark = valid_q[slot_q] ? rmark_q : MARK_EMPTY;
	assign match = (mark == MARK_LIVE) && (rlen_q == len_q) && (rkey_q == key_q);
	always_comb begin
		sts.hash_done = (byte_q == len_q);
		sts.last = (nprobe_q == (IdxW+1)'(TableSize - 1));
		case (func_q)
			FUNC_GET, FUNC_REM: sts.stop = (mark == MARK_EMPTY) || match;
			FUNC_PUT:           sts.stop = (mark != MARK_LIVE) || match;
			default:            sts.stop = 1'b1;
		endcase
	end

	// request registers and probe walk
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			key_q  <= key_bytes & kmask;
			len_q  <= len_sat;
			val_q  <= put_value;
			hash_q <= FnvBasis;
			byte_q <= '0;
		end else if (cmd.hash_step) begin
			hash_q <= hx * FnvPrime;
			byte_q <= byte_q + 4'd1;
		end
		if (cmd.set_home) begin
			slot_q   <= hash_q[IdxW-1:0];
			nprobe_q <= '0;
		end else if (cmd.advance) begin
			slot_q   <= slot_q + 1'b1;
			nprobe_q <= nprobe_q + 1'b1;
		end
	end

	// slot memories, registered read
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rmark_q <= mark_mem[slot_q];
			rkey_q  <= key_mem[slot_q];
			rlen_q  <= len_mem[slot_q];
			rval_q  <= val_mem[slot_q];
		end
		if (cmd.commit && sts.stop) begin
			if (func_q == FUNC_PUT) begin
				mark_mem[slot_q] <= MARK_LIVE;
				key_mem[slot_q]  <= key_q;
				len_mem[slot_q]  <= len_q;
				val_mem[slot_q]  <= val_q;
			end else if (func_q == FUNC_REM && match) begin
				mark_mem[slot_q] <= MARK_TOMB;
				val_mem[slot_q]  <= '0;
			end
		end
	end

	// control state and results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			live_q  <= '0;
			found   <= 1'b0;
			get_value <= '0;
			status  <= 1'b0;
		end else if (cmd.commit) begin
			found <= 1'b0; get_value <= '0; status <= 1'b0;
			if (sts.stop) begin
				case (func_q)
					FUNC_GET: begin
						found <= match;
						if (match) get_value <= rval_q;
					end
					FUNC_PUT: begin
						valid_q[slot_q] <= 1'b1;
						found <= match;
						if (!match) live_q <= live_q + 1'b1;
					end
					FUNC_REM: begin
						found <= match;
						if (match) live_q <= live_q - 1'b1;
					end
					default: ;
				endcase
			end else if (func_q == FUNC_PUT) begin
				status <= 1'b1;
			end
		end
	end
	assign live_entries = live_q;
endmodule

>>> rtl/lph_ctrl.sv
// Controller: sequences hashing, probing and result handoff.
`timescale 1ns / 1ps
module lph_ctrl import lph_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output lph_cmd_t cmd,
	input  lph_sts_t sts
);
	lph_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_HASH;
			ST_HASH:  if (sts.hash_done) state_d = ST_READ;
			ST_READ:  state_d = ST_CHECK;
			ST_CHECK: state_d = (sts.stop || sts.last) ? ST_DONE : ST_READ;
			ST_DONE:  if (out_ready) state_d = in_valid ? ST_HASH : ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_HASH: begin
				cmd.hash_step = !sts.hash_done;
				cmd.set_home = sts.hash_done;
			end
			ST_READ:  cmd.rd = 1'b1;
			ST_CHECK: begin
				cmd.commit = sts.stop || sts.last;
				cmd.advance = !(sts.stop || sts.last);
			end
			ST_DONE: begin
				out_valid = 1'b1;
				in_ready = out_ready;
				cmd.load = out_ready && in_valid;
			end
			default: ;
		endcase
	end

`ifndef ASSERT_OFF
	a_commit_check: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> state_q == ST_CHECK) else $error("commit outside check");
	a_done_after: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid) else $error("result not shown");
	a_read_then_check: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd |=> state_q == ST_CHECK) else $error("read not followed by check");
`endif
endmodule

>>> rtl/linear_probe_hash_table_top.sv
// Top level: linear probe hash table with FNV-1a home slot.
// Steps: accept, hash in HASH, READ and CHECK per probed slot, then result shown in DONE.
// One request at a time; a new one is accepted in DONE as the result is taken.
// Hash is one byte per cycle; each slot probed takes READ (registered read) then CHECK.
// Reset (arst_n low) empties all slots through per-slot valid bits and clears the count.
`timescale 1ns / 1ps
module linear_probe_hash_table_top import lph_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [1:0]      func,
	input  logic [KeyW-1:0] key_bytes,
	input  logic [3:0]      key_len,
	input  logic [ValW-1:0] put_value,
	output logic            out_valid,
	input  logic            out_ready,
	output logic            found,
	output logic [ValW-1:0] get_value,
	output logic            status,
	output logic [CntW-1:0] live_entries
);
	lph_cmd_t cmd;
	lph_sts_t sts;

	lph_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .cmd, .sts
	);
	lph_datapath u_dp (
		.clk, .arst_n, .cmd, .sts, .func, .key_bytes, .key_len, .put_value,
		.found, .get_value, .status, .live_entries
	);
endmodule
